// ===== sv/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared types, widths and helpers for the quaternion rotator
// Fixed-point widths of every pipeline stage, the stage enable bundle and
// the final round-and-saturate step.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  localparam int InW   = 16;             // quaternion and sample width
  localparam int OutW  = 18;             // result width
  localparam int Prod1W = 2 * InW;       // q * v
  localparam int PW    = Prod1W + 1;     // sum of three q * v terms
  localparam int Prod2W = PW + InW;      // p * q
  localparam int RW    = Prod2W + 2;     // sum of four p * q terms
  localparam int FracShift = 28;         // Q1.14 squared
  localparam int ShW   = RW - FracShift; // width after scaling down

  typedef logic signed [InW-1:0]    sample_t;
  typedef logic signed [OutW-1:0]   result_t;
  typedef logic signed [Prod1W-1:0] prod1_t;
  typedef logic signed [PW-1:0]     psum_t;
  typedef logic signed [Prod2W-1:0] prod2_t;
  typedef logic signed [RW-1:0]     rsum_t;

  // load strobes for the five register stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  localparam rsum_t RoundHalf = RW'(1) <<< (FracShift - 1);
  localparam logic signed [ShW-1:0] OutMax = ShW'((1 <<< (OutW - 1)) - 1);
  localparam logic signed [ShW-1:0] OutMin = -ShW'(1 <<< (OutW - 1));

  // round to nearest (ties up) from the 2^28 scale, then clamp to 18 bits
  function automatic result_t round_sat(input rsum_t r);
    rsum_t                  t;
    logic signed [ShW-1:0]  s;
    result_t                res;
    t = r + RoundHalf;
    s = signed'(t[RW-1:FracShift]);
    if (s > OutMax) begin
      res = OutMax[OutW-1:0];
    end else if (s < OutMin) begin
      res = OutMin[OutW-1:0];
    end else begin
      res = s[OutW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/quaternion_vector_rotate_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top: rotate accel and gyro samples to world frame
// Computes q * v * conj(q) for both vectors in two parallel lanes and
// tracks word valid bits along the five pipeline stages.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | quat_w..z, accel_x..z, gyro_x..z (16 b)
//  out     | out_valid / out_ready| world_accel_x..z, world_gyro_x..z (18 b)
//
//  One word enters per cycle while in_ready is high; the pipeline is the two
//  multiply stages and two adder stages of each lane plus the round stage.
//  Reset clears only the stage valid bits.
//  A stage holds when it is full and the stage after it cannot take its
//  word, so empty stages keep filling while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate_top import qvr_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  input  sample_t  quat_w,
  input  sample_t  quat_x,
  input  sample_t  quat_y,
  input  sample_t  quat_z,
  input  sample_t  accel_x,
  input  sample_t  accel_y,
  input  sample_t  accel_z,
  input  sample_t  gyro_x,
  input  sample_t  gyro_y,
  input  sample_t  gyro_z,
  output logic     out_valid,
  input  wire      out_ready,
  output result_t  world_accel_x,
  output result_t  world_accel_y,
  output result_t  world_accel_z,
  output result_t  world_gyro_x,
  output result_t  world_gyro_y,
  output result_t  world_gyro_z
);

  logic      vld1, vld2, vld3, vld4, vld5;
  stage_en_t en;

  // a stage may load when empty or when its word moves on this cycle
  always_comb begin
    en.s5 = !vld5 || out_ready;
    en.s4 = !vld4 || en.s5;
    en.s3 = !vld3 || en.s4;
    en.s2 = !vld2 || en.s3;
    en.s1 = !vld1 || en.s2;
  end

  assign in_ready  = en.s1;
  assign out_valid = vld5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (en.s1) vld1 <= in_valid;
      if (en.s2) vld2 <= vld1;
      if (en.s3) vld3 <= vld2;
      if (en.s4) vld4 <= vld3;
      if (en.s5) vld5 <= vld4;
    end
  end

  qvr_lane u_accel (
    .clk (clk),
    .en  (en),
    .q_w (quat_w),
    .q_x (quat_x),
    .q_y (quat_y),
    .q_z (quat_z),
    .v_x (accel_x),
    .v_y (accel_y),
    .v_z (accel_z),
    .r_x (world_accel_x),
    .r_y (world_accel_y),
    .r_z (world_accel_z)
  );

  qvr_lane u_gyro (
    .clk (clk),
    .en  (en),
    .q_w (quat_w),
    .q_x (quat_x),
    .q_y (quat_y),
    .q_z (quat_z),
    .v_x (gyro_x),
    .v_y (gyro_y),
    .v_z (gyro_z),
    .r_x (world_gyro_x),
    .r_y (world_gyro_y),
    .r_z (world_gyro_z)
  );

endmodule

`default_nettype wire

// ===== sv/qvr_lane.sv =====
// ----------------------------------------------------------------------------
// qvr_lane: five-stage datapath rotating one vector by a quaternion
// Stage 1 forms q*v products, stage 2 sums them into p = q*(0,v), stage 3
// forms p*q products, stage 4 sums them into the vector part of p*conj(q),
// stage 5 rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_lane import qvr_pkg::*; (
  input  wire        clk,
  input  stage_en_t  en,
  input  sample_t    q_w,
  input  sample_t    q_x,
  input  sample_t    q_y,
  input  sample_t    q_z,
  input  sample_t    v_x,
  input  sample_t    v_y,
  input  sample_t    v_z,
  output result_t    r_x,
  output result_t    r_y,
  output result_t    r_z
);

  // stage 1: m_ab = q_a * v_b
  prod1_t m_wx, m_wy, m_wz;
  prod1_t m_xx, m_xy, m_xz;
  prod1_t m_yx, m_yy, m_yz;
  prod1_t m_zx, m_zy, m_zz;
  sample_t q1_w, q1_x, q1_y, q1_z;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      m_wx <= q_w * v_x;  m_wy <= q_w * v_y;  m_wz <= q_w * v_z;
      m_xx <= q_x * v_x;  m_xy <= q_x * v_y;  m_xz <= q_x * v_z;
      m_yx <= q_y * v_x;  m_yy <= q_y * v_y;  m_yz <= q_y * v_z;
      m_zx <= q_z * v_x;  m_zy <= q_z * v_y;  m_zz <= q_z * v_z;
      q1_w <= q_w;  q1_x <= q_x;  q1_y <= q_y;  q1_z <= q_z;
    end
  end

  // stage 2: p = q * (0, v)
  psum_t p_w, p_x, p_y, p_z;
  sample_t q2_w, q2_x, q2_y, q2_z;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_w <= -PW'(m_xx) - PW'(m_yy) - PW'(m_zz);
      p_x <=  PW'(m_wx) + PW'(m_yz) - PW'(m_zy);
      p_y <=  PW'(m_wy) - PW'(m_xz) + PW'(m_zx);
      p_z <=  PW'(m_wz) + PW'(m_xy) - PW'(m_yx);
      q2_w <= q1_w;  q2_x <= q1_x;  q2_y <= q1_y;  q2_z <= q1_z;
    end
  end

  // stage 3: n_ab = p_a * q_b, only the twelve cross terms are needed
  prod2_t n_wx, n_wy, n_wz;
  prod2_t n_xw, n_xy, n_xz;
  prod2_t n_yw, n_yx, n_yz;
  prod2_t n_zw, n_zx, n_zy;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      n_wx <= p_w * q2_x;  n_wy <= p_w * q2_y;  n_wz <= p_w * q2_z;
      n_xw <= p_x * q2_w;  n_xy <= p_x * q2_y;  n_xz <= p_x * q2_z;
      n_yw <= p_y * q2_w;  n_yx <= p_y * q2_x;  n_yz <= p_y * q2_z;
      n_zw <= p_z * q2_w;  n_zx <= p_z * q2_x;  n_zy <= p_z * q2_y;
    end
  end

  // stage 4: vector part of p * conj(q)
  rsum_t s_x, s_y, s_z;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s_x <= -RW'(n_wx) + RW'(n_xw) - RW'(n_yz) + RW'(n_zy);
      s_y <= -RW'(n_wy) + RW'(n_xz) + RW'(n_yw) - RW'(n_zx);
      s_z <= -RW'(n_wz) - RW'(n_xy) + RW'(n_yx) + RW'(n_zw);
    end
  end

  // stage 5: round and saturate into the output register
  always_ff @(posedge clk) begin
    if (en.s5) begin
      r_x <= round_sat(s_x);
      r_y <= round_sat(s_y);
      r_z <= round_sat(s_z);
    end
  end

endmodule

`default_nettype wire
